// ===== rtl/mlp_relu_sigmoid_online_train_defines.svh =====
// Assertion macros used by the top level of the perceptron block.
`ifndef MLP_RELU_SIGMOID_ONLINE_TRAIN_DEFINES_SVH
`define MLP_RELU_SIGMOID_ONLINE_TRAIN_DEFINES_SVH

// Checks that a consequence holds in the same cycle as its cause.
`define MLPRS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that a consequence holds in the cycle after its cause.
`define MLPRS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mlprs_pkg.sv =====
// Types, constants and arithmetic helpers of the perceptron block.
package mlprs_pkg;

    localparam int MAX_INPUTS = 128;
    localparam int MAX_HIDDEN = 64;
    localparam int WORD_BITS  = 16;
    localparam int IN_AW      = $clog2(MAX_INPUTS);
    localparam int HID_AW     = $clog2(MAX_HIDDEN);
    localparam int HW_AW      = IN_AW + HID_AW;
    localparam int HW_DEPTH   = MAX_HIDDEN * MAX_INPUTS;

    // Datapath widths.
    localparam int ACC_BITS  = 40;
    localparam int MA_BITS   = 24;
    localparam int MB_BITS   = 18;
    localparam int PROD_BITS = MA_BITS + MB_BITS;
    localparam int STEP_BITS = 18;
    localparam int HS_BITS   = 22;
    localparam int SAT_BITS  = 44;

    localparam logic [15:0] TGT_HIGH = 16'd58982;
    localparam logic [15:0] TGT_LOW  = 16'd6554;
    localparam logic [15:0] LR_RESET = 16'd655;
    localparam logic [6:0]  HC_RESET = 7'd49;

    // Configuration register indexes.
    localparam logic CFG_LEARN_RATE   = 1'b0;
    localparam logic CFG_HIDDEN_COUNT = 1'b1;

    typedef logic signed [WORD_BITS-1:0] t_word;

    typedef enum logic [1:0] {
        FN_HID_WR  = 2'd0,
        FN_OUT_WR  = 2'd1,
        FN_FEATURE = 2'd2,
        FN_TRAIN   = 2'd3
    } t_func;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_HBIAS,
        OP_HSUM,
        OP_HFIN,
        OP_OBIAS,
        OP_OSUM,
        OP_OFIN,
        OP_STEP,
        OP_OWUPD,
        OP_OBUPD,
        OP_HS,
        OP_HW,
        OP_HB
    } t_op;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_HBIAS,
        S_HSUM,
        S_HFIN,
        S_OBIAS,
        S_OSUM,
        S_OFIN,
        S_STEP,
        S_OWUPD,
        S_OBUPD,
        S_HS,
        S_HCHK,
        S_HW,
        S_HB,
        S_WAIT
    } t_state;

    typedef struct packed {
        t_op               op;
        logic [HID_AW-1:0] i;
        logic [IN_AW-1:0]  j;
        logic              train;
        logic              correct;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic out_full;
        logic hact;
    } t_stat;

    // Saturates a wide signed value to one stored word.
    function automatic t_word sat_word(input logic signed [SAT_BITS-1:0] x);
        logic signed [SAT_BITS-1:0] hi;
        logic signed [SAT_BITS-1:0] lo;
        hi = SAT_BITS'({1'b0, {(WORD_BITS-1){1'b1}}});
        lo = -hi - SAT_BITS'(1);
        if (x > hi) begin
            return t_word'(hi);
        end else if (x < lo) begin
            return t_word'(lo);
        end
        return t_word'(x);
    endfunction

    // Piecewise-linear sigmoid, Q4.12 in, unsigned Q0.16 out.
    function automatic logic [15:0] sigmoid_q16(input t_word x);
        logic [16:0] a;
        logic [16:0] y;
        a = x[WORD_BITS-1] ? (17'd0 - 17'(x)) : 17'(x);
        if (a >= 17'd20480) begin
            y = 17'd65536;
        end else if (a >= 17'd9728) begin
            y = (a >> 1) + 17'd55296;
        end else if (a >= 17'd4096) begin
            y = (a << 1) + 17'd40960;
        end else begin
            y = (a << 2) + 17'd32768;
        end
        if (x[WORD_BITS-1]) begin
            y = 17'd65536 - y;
        end
        if (y > 17'd65535) begin
            y = 17'd65535;
        end
        return y[15:0];
    endfunction

endpackage

// ===== rtl/mlprs_ctrl.sv =====
// Sequencer that walks the forward pass, training step and clearing pass.
module mlprs_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  mlprs_pkg::t_func    i_func,
    input  logic [7:0]          i_position,
    input  logic                i_last,
    input  logic                i_was_correct,
    input  logic [6:0]          i_hidden_count,
    input  mlprs_pkg::t_stat    i_stat,
    output logic                o_in_stall,
    output logic                o_load,
    output mlprs_pkg::t_cmd     o_cmd
);

    mlprs_pkg::t_state r_state, n_state;
    mlprs_pkg::t_state r_after, n_after;
    logic [6:0] r_i, n_i;
    logic [7:0] r_j, n_j;
    logic [7:0] r_nf, n_nf;
    logic       r_train, n_train;
    logic       r_correct, n_correct;
    logic [6:0] nh;
    logic       i_end;
    logic       j_end;

    // Neurons in use, clamped to the array size.
    assign nh    = (i_hidden_count > 7'(mlprs_pkg::MAX_HIDDEN)) ?
                   7'(mlprs_pkg::MAX_HIDDEN) : i_hidden_count;
    assign i_end = ((r_i + 7'd1) == nh);
    assign j_end = ((r_j + 8'd1) == r_nf);

    // State and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= mlprs_pkg::S_CLEAR;
            r_after   <= mlprs_pkg::S_IDLE;
            r_i       <= '0;
            r_j       <= '0;
            r_nf      <= '0;
            r_train   <= 1'b0;
            r_correct <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_after   <= n_after;
            r_i       <= n_i;
            r_j       <= n_j;
            r_nf      <= n_nf;
            r_train   <= n_train;
            r_correct <= n_correct;
        end
    end

    // Next state and command issue.
    always_comb begin
        n_state     = r_state;
        n_after     = r_after;
        n_i         = r_i;
        n_j         = r_j;
        n_nf        = r_nf;
        n_train     = r_train;
        n_correct   = r_correct;
        o_in_stall  = 1'b1;
        o_load      = 1'b0;
        o_cmd.op      = mlprs_pkg::OP_NONE;
        o_cmd.i       = r_i[mlprs_pkg::HID_AW-1:0];
        o_cmd.j       = r_j[mlprs_pkg::IN_AW-1:0];
        o_cmd.train   = r_train;
        o_cmd.correct = r_correct;
        unique case (r_state)
            mlprs_pkg::S_CLEAR: begin
                o_cmd.op = mlprs_pkg::OP_CLEAR;
                n_j = r_j + 8'd1;
                if (r_j == 8'(mlprs_pkg::MAX_INPUTS - 1)) begin
                    n_j = '0;
                    n_i = r_i + 7'd1;
                    if (r_i == 7'(mlprs_pkg::MAX_HIDDEN - 1)) begin
                        n_i     = '0;
                        n_state = mlprs_pkg::S_IDLE;
                    end
                end
            end
            mlprs_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                o_load     = i_in_valid;
                n_i = '0;
                n_j = '0;
                if (i_in_valid && ((i_func == mlprs_pkg::FN_TRAIN) ||
                        (i_func == mlprs_pkg::FN_FEATURE && i_last))) begin
                    n_train   = (i_func == mlprs_pkg::FN_TRAIN);
                    n_correct = i_was_correct;
                    if (i_func == mlprs_pkg::FN_FEATURE) begin
                        n_nf = (i_position >= 8'(mlprs_pkg::MAX_INPUTS)) ?
                               8'(mlprs_pkg::MAX_INPUTS) : (i_position + 8'd1);
                    end
                    n_state = (nh != 7'd0) ? mlprs_pkg::S_HBIAS : mlprs_pkg::S_OBIAS;
                end
            end
            mlprs_pkg::S_HBIAS: begin
                o_cmd.op = mlprs_pkg::OP_HBIAS;
                n_j = '0;
                n_state = (r_nf != 8'd0) ? mlprs_pkg::S_HSUM : mlprs_pkg::S_HFIN;
            end
            mlprs_pkg::S_HSUM: begin
                o_cmd.op = mlprs_pkg::OP_HSUM;
                n_j = r_j + 8'd1;
                if (j_end) begin
                    n_state = mlprs_pkg::S_HFIN;
                end
            end
            mlprs_pkg::S_HFIN: begin
                o_cmd.op = mlprs_pkg::OP_HFIN;
                n_i = r_i + 7'd1;
                if (i_end) begin
                    n_state = mlprs_pkg::S_WAIT;
                    n_after = mlprs_pkg::S_OBIAS;
                end else begin
                    n_state = mlprs_pkg::S_HBIAS;
                end
            end
            mlprs_pkg::S_OBIAS: begin
                o_cmd.op = mlprs_pkg::OP_OBIAS;
                n_i = '0;
                n_state = (nh != 7'd0) ? mlprs_pkg::S_OSUM : mlprs_pkg::S_OFIN;
            end
            mlprs_pkg::S_OSUM: begin
                o_cmd.op = mlprs_pkg::OP_OSUM;
                n_i = r_i + 7'd1;
                if (i_end) begin
                    n_state = mlprs_pkg::S_OFIN;
                end
            end
            mlprs_pkg::S_OFIN: begin
                // The result beat waits for a free output register.
                if (!i_stat.out_full) begin
                    o_cmd.op = mlprs_pkg::OP_OFIN;
                    n_state  = mlprs_pkg::S_WAIT;
                    n_after  = r_train ? mlprs_pkg::S_STEP : mlprs_pkg::S_IDLE;
                end
            end
            mlprs_pkg::S_STEP: begin
                o_cmd.op = mlprs_pkg::OP_STEP;
                n_i      = '0;
                n_state  = mlprs_pkg::S_WAIT;
                n_after  = (nh != 7'd0) ? mlprs_pkg::S_OWUPD : mlprs_pkg::S_OBUPD;
            end
            mlprs_pkg::S_OWUPD: begin
                o_cmd.op = mlprs_pkg::OP_OWUPD;
                n_i = r_i + 7'd1;
                if (i_end) begin
                    n_state = mlprs_pkg::S_OBUPD;
                end
            end
            mlprs_pkg::S_OBUPD: begin
                o_cmd.op = mlprs_pkg::OP_OBUPD;
                n_i      = '0;
                n_state  = mlprs_pkg::S_WAIT;
                n_after  = (nh != 7'd0) ? mlprs_pkg::S_HS : mlprs_pkg::S_IDLE;
            end
            mlprs_pkg::S_HS: begin
                o_cmd.op = mlprs_pkg::OP_HS;
                n_state  = mlprs_pkg::S_WAIT;
                n_after  = mlprs_pkg::S_HCHK;
            end
            mlprs_pkg::S_HCHK: begin
                // Neurons with no activation keep their hidden weights.
                n_j = '0;
                if (i_stat.hact) begin
                    n_state = (r_nf != 8'd0) ? mlprs_pkg::S_HW : mlprs_pkg::S_HB;
                end else begin
                    n_i = r_i + 7'd1;
                    n_state = i_end ? mlprs_pkg::S_IDLE : mlprs_pkg::S_HS;
                end
            end
            mlprs_pkg::S_HW: begin
                o_cmd.op = mlprs_pkg::OP_HW;
                n_j = r_j + 8'd1;
                if (j_end) begin
                    n_state = mlprs_pkg::S_HB;
                end
            end
            mlprs_pkg::S_HB: begin
                o_cmd.op = mlprs_pkg::OP_HB;
                n_i = r_i + 7'd1;
                if (i_end) begin
                    n_state = mlprs_pkg::S_WAIT;
                    n_after = mlprs_pkg::S_IDLE;
                end else begin
                    n_state = mlprs_pkg::S_HS;
                end
            end
            mlprs_pkg::S_WAIT: begin
                if (i_stat.empty) begin
                    n_state = r_after;
                end
            end
            default: begin
                n_state = mlprs_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/mlprs_datapath.sv =====
// Parameter memories, shared multiplier pipeline, accumulator and result register.
module mlprs_datapath (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  mlprs_pkg::t_cmd         i_cmd,
    input  logic                    i_load,
    input  mlprs_pkg::t_func        i_func,
    input  logic [5:0]              i_neuron,
    input  logic [7:0]              i_position,
    input  logic signed [15:0]      i_value,
    input  logic [15:0]             i_learn_rate,
    input  logic                    i_out_stall,
    output mlprs_pkg::t_stat        o_stat,
    output logic                    o_out_valid,
    output logic [15:0]             o_confidence,
    output logic                    o_from_training
);

    localparam int HA = mlprs_pkg::HID_AW;
    localparam int IA = mlprs_pkg::IN_AW;

    // Memories and their registered read data.
    mlprs_pkg::t_word r_hw_mem [mlprs_pkg::HW_DEPTH];
    mlprs_pkg::t_word r_fb_mem [mlprs_pkg::MAX_INPUTS];
    mlprs_pkg::t_word r_hb_mem [mlprs_pkg::MAX_HIDDEN];
    mlprs_pkg::t_word r_ow_mem [mlprs_pkg::MAX_HIDDEN];
    mlprs_pkg::t_word r_ha_mem [mlprs_pkg::MAX_HIDDEN];
    mlprs_pkg::t_word r_hw_rd, r_fb_rd, r_hb_rd, r_ow_rd, r_ha_rd;

    logic                   hw_we, fb_we, hb_we, ow_we, ha_we;
    logic [mlprs_pkg::HW_AW-1:0] hw_wa;
    logic [IA-1:0]          fb_wa;
    logic [HA-1:0]          hb_wa, ow_wa, ha_wa;
    mlprs_pkg::t_word       hw_wd, fb_wd, hb_wd, ow_wd, ha_wd;

    // Pipeline registers.
    logic                   r_s1_v, r_s2_v;
    mlprs_pkg::t_op         r_s1_op, r_s2_op;
    logic [HA-1:0]          r_s1_i, r_s2_i;
    logic [IA-1:0]          r_s1_j, r_s2_j;
    logic                   r_s1_train, r_s2_train;
    logic                   r_s1_correct;
    logic signed [mlprs_pkg::PROD_BITS-1:0] r_s2_prod;
    mlprs_pkg::t_word       r_s2_word;

    // Working registers.
    logic signed [mlprs_pkg::ACC_BITS-1:0]  r_acc;
    logic signed [mlprs_pkg::STEP_BITS-1:0] r_step;
    logic signed [mlprs_pkg::HS_BITS-1:0]   r_hs;
    logic                   r_hact;
    logic [15:0]            r_pred;
    mlprs_pkg::t_word       r_ob;
    logic                   r_out_valid;
    logic [15:0]            r_conf;
    logic                   r_from_train;

    // Stage logic.
    logic signed [mlprs_pkg::MA_BITS-1:0]   ma;
    logic signed [mlprs_pkg::MB_BITS-1:0]   mb;
    logic signed [mlprs_pkg::PROD_BITS-1:0] prod;
    logic signed [17:0]     err;
    logic [15:0]            tgt;
    mlprs_pkg::t_word       s1_word;
    logic signed [mlprs_pkg::ACC_BITS-1:0]  acc_sh;
    mlprs_pkg::t_word       acc_word;
    mlprs_pkg::t_word       relu_word;
    logic [15:0]            conf;
    logic signed [mlprs_pkg::PROD_BITS-1:0] p16, p12;
    mlprs_pkg::t_word       upd16;
    logic signed [mlprs_pkg::STEP_BITS-1:0] step_r4;
    logic signed [mlprs_pkg::HS_BITS-1:0]   hs_r4;
    mlprs_pkg::t_word       ob_new, hb_new;
    logic                   clr_row;

    assign clr_row = (i_cmd.op == mlprs_pkg::OP_CLEAR) && (i_cmd.j == '0);

    // Hidden weight write port.
    always_comb begin
        hw_we = 1'b0;
        hw_wa = {i_cmd.i, i_cmd.j};
        hw_wd = '0;
        priority if (i_cmd.op == mlprs_pkg::OP_CLEAR) begin
            hw_we = 1'b1;
        end else if (i_load && i_func == mlprs_pkg::FN_HID_WR &&
                     i_position < 8'(mlprs_pkg::MAX_INPUTS)) begin
            hw_we = 1'b1;
            hw_wa = {i_neuron[HA-1:0], i_position[IA-1:0]};
            hw_wd = i_value;
        end else if (r_s2_v && r_s2_op == mlprs_pkg::OP_HW) begin
            hw_we = 1'b1;
            hw_wa = {r_s2_i, r_s2_j};
            hw_wd = upd16;
        end else begin
            hw_we = 1'b0;
        end
    end

    // Feature buffer write port.
    always_comb begin
        fb_we = i_load && i_func == mlprs_pkg::FN_FEATURE &&
                i_position < 8'(mlprs_pkg::MAX_INPUTS);
        fb_wa = i_position[IA-1:0];
        fb_wd = i_value;
    end

    // Hidden bias write port.
    always_comb begin
        hb_we = 1'b0;
        hb_wa = i_cmd.i;
        hb_wd = '0;
        priority if (clr_row) begin
            hb_we = 1'b1;
        end else if (i_load && i_func == mlprs_pkg::FN_HID_WR &&
                     i_position == 8'(mlprs_pkg::MAX_INPUTS)) begin
            hb_we = 1'b1;
            hb_wa = i_neuron[HA-1:0];
            hb_wd = i_value;
        end else if (r_s2_v && r_s2_op == mlprs_pkg::OP_HB) begin
            hb_we = 1'b1;
            hb_wa = r_s2_i;
            hb_wd = hb_new;
        end else begin
            hb_we = 1'b0;
        end
    end

    // Output weight write port.
    always_comb begin
        ow_we = 1'b0;
        ow_wa = i_cmd.i;
        ow_wd = '0;
        priority if (clr_row) begin
            ow_we = 1'b1;
        end else if (i_load && i_func == mlprs_pkg::FN_OUT_WR &&
                     i_position < 8'(mlprs_pkg::MAX_HIDDEN)) begin
            ow_we = 1'b1;
            ow_wa = i_position[HA-1:0];
            ow_wd = i_value;
        end else if (r_s2_v && r_s2_op == mlprs_pkg::OP_OWUPD) begin
            ow_we = 1'b1;
            ow_wa = r_s2_i;
            ow_wd = upd16;
        end else begin
            ow_we = 1'b0;
        end
    end

    // Hidden activation write port.
    always_comb begin
        ha_we = 1'b0;
        ha_wa = i_cmd.i;
        ha_wd = '0;
        priority if (clr_row) begin
            ha_we = 1'b1;
        end else if (r_s2_v && r_s2_op == mlprs_pkg::OP_HFIN) begin
            ha_we = 1'b1;
            ha_wa = r_s2_i;
            ha_wd = relu_word;
        end else begin
            ha_we = 1'b0;
        end
    end

    // Memories: one write and one registered read each.
    always_ff @(posedge i_clk) begin
        if (hw_we) begin
            r_hw_mem[hw_wa] <= hw_wd;
        end
        r_hw_rd <= r_hw_mem[{i_cmd.i, i_cmd.j}];
    end

    always_ff @(posedge i_clk) begin
        if (fb_we) begin
            r_fb_mem[fb_wa] <= fb_wd;
        end
        r_fb_rd <= r_fb_mem[i_cmd.j];
    end

    always_ff @(posedge i_clk) begin
        if (hb_we) begin
            r_hb_mem[hb_wa] <= hb_wd;
        end
        r_hb_rd <= r_hb_mem[i_cmd.i];
    end

    always_ff @(posedge i_clk) begin
        if (ow_we) begin
            r_ow_mem[ow_wa] <= ow_wd;
        end
        r_ow_rd <= r_ow_mem[i_cmd.i];
    end

    always_ff @(posedge i_clk) begin
        if (ha_we) begin
            r_ha_mem[ha_wa] <= ha_wd;
        end
        r_ha_rd <= r_ha_mem[i_cmd.i];
    end

    // Pipeline valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            r_s1_v <= (i_cmd.op != mlprs_pkg::OP_NONE) && (i_cmd.op != mlprs_pkg::OP_CLEAR);
            r_s2_v <= r_s1_v;
        end
    end

    // Pipeline payload.
    always_ff @(posedge i_clk) begin
        r_s1_op      <= i_cmd.op;
        r_s1_i       <= i_cmd.i;
        r_s1_j       <= i_cmd.j;
        r_s1_train   <= i_cmd.train;
        r_s1_correct <= i_cmd.correct;
        r_s2_op      <= r_s1_op;
        r_s2_i       <= r_s1_i;
        r_s2_j       <= r_s1_j;
        r_s2_train   <= r_s1_train;
        r_s2_prod    <= prod;
        r_s2_word    <= s1_word;
    end

    // Error against the target, from the latest prediction.
    assign tgt = r_s1_correct ? mlprs_pkg::TGT_HIGH : mlprs_pkg::TGT_LOW;
    assign err = $signed({2'b00, tgt}) - $signed({2'b00, r_pred});

    // Operand selection for the shared multiplier.
    always_comb begin
        ma      = '0;
        mb      = '0;
        s1_word = '0;
        unique case (r_s1_op)
            mlprs_pkg::OP_HBIAS: s1_word = r_hb_rd;
            mlprs_pkg::OP_HSUM: begin
                ma = mlprs_pkg::MA_BITS'(r_fb_rd);
                mb = mlprs_pkg::MB_BITS'(r_hw_rd);
            end
            mlprs_pkg::OP_OSUM: begin
                ma = mlprs_pkg::MA_BITS'(r_ha_rd);
                mb = mlprs_pkg::MB_BITS'(r_ow_rd);
            end
            mlprs_pkg::OP_STEP: begin
                ma = mlprs_pkg::MA_BITS'($signed({1'b0, i_learn_rate}));
                mb = mlprs_pkg::MB_BITS'(err);
            end
            mlprs_pkg::OP_OWUPD: begin
                ma      = mlprs_pkg::MA_BITS'(r_step);
                mb      = mlprs_pkg::MB_BITS'(r_ha_rd);
                s1_word = r_ow_rd;
            end
            mlprs_pkg::OP_HS: begin
                ma      = mlprs_pkg::MA_BITS'(r_step);
                mb      = mlprs_pkg::MB_BITS'(r_ow_rd);
                s1_word = r_ha_rd;
            end
            mlprs_pkg::OP_HW: begin
                ma      = mlprs_pkg::MA_BITS'(r_hs);
                mb      = mlprs_pkg::MB_BITS'(r_fb_rd);
                s1_word = r_hw_rd;
            end
            mlprs_pkg::OP_HB: s1_word = r_hb_rd;
            default: begin
                ma = '0;
            end
        endcase
    end

    assign prod = ma * mb;

    // Rounding and saturation at the end of the pipeline.
    assign acc_sh    = (r_acc + mlprs_pkg::ACC_BITS'(2048)) >>> 12;
    assign acc_word  = mlprs_pkg::sat_word(mlprs_pkg::SAT_BITS'(acc_sh));
    assign relu_word = acc_word[mlprs_pkg::WORD_BITS-1] ? '0 : acc_word;
    assign conf      = mlprs_pkg::sigmoid_q16(acc_word);
    assign p16       = (r_s2_prod + mlprs_pkg::PROD_BITS'(32768)) >>> 16;
    assign p12       = (r_s2_prod + mlprs_pkg::PROD_BITS'(2048)) >>> 12;
    assign upd16     = mlprs_pkg::sat_word(mlprs_pkg::SAT_BITS'(r_s2_word) +
                                           mlprs_pkg::SAT_BITS'(p16));
    assign step_r4   = (r_step + mlprs_pkg::STEP_BITS'(8)) >>> 4;
    assign hs_r4     = (r_hs + mlprs_pkg::HS_BITS'(8)) >>> 4;
    assign ob_new    = mlprs_pkg::sat_word(mlprs_pkg::SAT_BITS'(r_ob) +
                                           mlprs_pkg::SAT_BITS'(step_r4));
    assign hb_new    = mlprs_pkg::sat_word(mlprs_pkg::SAT_BITS'(r_s2_word) +
                                           mlprs_pkg::SAT_BITS'(hs_r4));

    // Accumulator, prediction, learning step, hidden error scale and activity flag.
    always_ff @(posedge i_clk) begin
        if (r_s2_v) begin
            unique case (r_s2_op)
                mlprs_pkg::OP_HBIAS:
                    r_acc <= mlprs_pkg::ACC_BITS'(r_s2_word) <<< 12;
                mlprs_pkg::OP_OBIAS:
                    r_acc <= mlprs_pkg::ACC_BITS'(r_ob) <<< 12;
                mlprs_pkg::OP_HSUM, mlprs_pkg::OP_OSUM:
                    r_acc <= r_acc + mlprs_pkg::ACC_BITS'(r_s2_prod);
                mlprs_pkg::OP_OFIN:
                    r_pred <= conf;
                mlprs_pkg::OP_STEP:
                    r_step <= mlprs_pkg::STEP_BITS'(p16);
                mlprs_pkg::OP_HS: begin
                    r_hs   <= mlprs_pkg::HS_BITS'(p12);
                    r_hact <= (r_s2_word > 0);
                end
                default: begin
                end
            endcase
        end
    end

    // Output bias register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob <= '0;
        end else if (i_load && i_func == mlprs_pkg::FN_OUT_WR &&
                     i_position == 8'(mlprs_pkg::MAX_INPUTS)) begin
            r_ob <= i_value;
        end else if (r_s2_v && r_s2_op == mlprs_pkg::OP_OBUPD) begin
            r_ob <= ob_new;
        end
    end

    // Result register: holds one beat until the consumer takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_s2_v && r_s2_op == mlprs_pkg::OP_OFIN) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_v && r_s2_op == mlprs_pkg::OP_OFIN) begin
            r_conf       <= conf;
            r_from_train <= r_s2_train;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_confidence    = r_conf;
    assign o_from_training = r_from_train;
    assign o_stat.empty    = !r_s1_v && !r_s2_v;
    assign o_stat.out_full = r_out_valid;
    assign o_stat.hact     = r_hact;

endmodule

// ===== rtl/mlp_relu_sigmoid_online_train.sv =====
// Two-layer ReLU/sigmoid perceptron with online training: top level.
// After reset the block clears its weight memory, one word a cycle,
// before it takes the first input beat (configuration writes are taken
// throughout). Parameter writes and feature elements not marked last
// leave the block ready for the next beat. A forward pass walks the bias
// and features of each neuron in use, then the output layer; a training
// step updates the output weights and bias, then the weights and bias of
// each active hidden neuron. All products go through one multiplier
// pipeline at one product a cycle; the state walks memories word by word.
`include "mlp_relu_sigmoid_online_train_defines.svh"

module mlp_relu_sigmoid_online_train (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_func,
    input  logic [5:0]         i_neuron,
    input  logic [7:0]         i_position,
    input  logic signed [15:0] i_value,
    input  logic               i_last,
    input  logic               i_was_correct,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [15:0]        o_confidence,
    output logic               o_from_training
);

    logic [15:0]          r_learn_rate;
    logic [6:0]           r_hidden_count;
    mlprs_pkg::t_cmd      cmd;
    mlprs_pkg::t_stat     stat;
    mlprs_pkg::t_func     func;
    logic                 load;
    logic                 in_acc;

    assign func   = mlprs_pkg::t_func'(i_func);
    assign in_acc = i_in_valid && !o_in_stall;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_learn_rate   <= mlprs_pkg::LR_RESET;
            r_hidden_count <= mlprs_pkg::HC_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == mlprs_pkg::CFG_LEARN_RATE) begin
                r_learn_rate <= i_cfg_data;
            end
            if (i_cfg_index == mlprs_pkg::CFG_HIDDEN_COUNT) begin
                r_hidden_count <= i_cfg_data[6:0];
            end
        end
    end

    // Sequencer.
    mlprs_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_func         (func),
        .i_position     (i_position),
        .i_last         (i_last),
        .i_was_correct  (i_was_correct),
        .i_hidden_count (r_hidden_count),
        .i_stat         (stat),
        .o_in_stall     (o_in_stall),
        .o_load         (load),
        .o_cmd          (cmd)
    );

    // Memories and arithmetic.
    mlprs_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_load          (load),
        .i_func          (func),
        .i_neuron        (i_neuron),
        .i_position      (i_position),
        .i_value         (i_value),
        .i_learn_rate    (r_learn_rate),
        .i_out_stall     (i_out_stall),
        .o_stat          (stat),
        .o_out_valid     (o_out_valid),
        .o_confidence    (o_confidence),
        .o_from_training (o_from_training)
    );

    // A beat that yields a result keeps the input side busy.
    `MLPRS_ASSERT_NEXT(a_result_item_busy, in_acc && (func == mlprs_pkg::FN_TRAIN || (func == mlprs_pkg::FN_FEATURE && i_last)), o_in_stall, "result item did not start the sequencer")

    // Parameter writes complete in the cycle they are taken.
    `MLPRS_ASSERT_NEXT(a_param_write_idle, in_acc && (func == mlprs_pkg::FN_HID_WR || func == mlprs_pkg::FN_OUT_WR), !o_in_stall, "parameter write left the block busy")

    // A result appears only while the sequencer is working on an item.
    `MLPRS_ASSERT_SAME(a_result_while_busy, $rose(o_out_valid), $past(o_in_stall), "result appeared with no item in progress")

endmodule
